### rtl/bgp_pkg.sv
// ----------------------------------------------------------------------------
// bgp_pkg
// Shared types and constants for the block-graphics pixel plotter.
// ----------------------------------------------------------------------------
`default_nettype none

package bgp_pkg;

  localparam int unsigned DefCellsPerRow = 64;
  localparam int unsigned DefCellRows    = 16;

  localparam int unsigned CellW = 8;

  localparam logic [CellW-1:0] GfxLow    = 8'd128;
  localparam logic [CellW-1:0] GfxHigh   = 8'd191;
  localparam logic [CellW-1:0] SpaceCode = 8'd32;

  // floor(y / 3) == (y * 43) >> 7 for 0 <= y < 64
  localparam int unsigned RecipThird = 43;
  localparam int unsigned RecipShift = 7;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_LINE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic       on_screen;
    logic [2:0] bit_sel;
  } pix_loc_t;

endpackage

`default_nettype wire

### rtl/bgp_cell_ram.sv
// ----------------------------------------------------------------------------
// bgp_cell_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bgp_cell_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       wr_en_i,
  input  wire logic [AW-1:0]              wr_addr_i,
  input  wire logic [bgp_pkg::CellW-1:0]  wr_data_i,
  input  wire logic                       rd_en_i,
  input  wire logic [AW-1:0]              rd_addr_i,
  output logic      [bgp_pkg::CellW-1:0]  rd_data_o
);
  import bgp_pkg::*;

  logic [CellW-1:0] mem [DEPTH];
  logic [CellW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/bgp_pixel_map.sv
// ----------------------------------------------------------------------------
// bgp_pixel_map
// Maps a pixel coordinate to its cell address, bit position and visibility.
// ----------------------------------------------------------------------------
`default_nettype none

module bgp_pixel_map #(
  parameter int unsigned CELLS_PER_ROW = 64,
  parameter int unsigned CELL_ROWS     = 16,
  parameter int unsigned AW            = 10
) (
  input  wire logic [7:0]         pixel_x_i,
  input  wire logic [5:0]         pixel_y_i,
  output logic      [AW-1:0]      cell_addr_o,
  output bgp_pkg::pix_loc_t       loc_o
);
  import bgp_pkg::*;

  logic [12:0] prod;
  logic [4:0]  row;
  logic [5:0]  three_row;
  logic [1:0]  sub_row;
  logic [6:0]  col;

  always_comb begin
    prod      = 13'(pixel_y_i) * 13'(RecipThird);
    row       = 5'(prod >> RecipShift);
    three_row = {row, 1'b0} + {1'b0, row};
    sub_row   = 2'(pixel_y_i - three_row);
    col       = pixel_x_i[7:1];

    loc_o.bit_sel   = 3'(pixel_x_i[0]) + {sub_row, 1'b0};
    loc_o.on_screen = (32'(col) < CELLS_PER_ROW) && (32'(row) < CELL_ROWS);
    cell_addr_o     = AW'(row) * AW'(CELLS_PER_ROW) + AW'(col);
  end

endmodule

`default_nettype wire

### rtl/block_graphics_pixel_plotter.sv
// ----------------------------------------------------------------------------
// block_graphics_pixel_plotter
// Plot and read: the result beat comes from a register; the next input beat can be
// accepted in the cycle the result beat is taken. Line: each visible column is
// read and written back, hidden columns are skipped; an empty line writes nothing.
// Clear writes spaces to every cell, then returns a result beat. Input waits
// while a result beat is stalled. Reset starts a clearing pass that writes
// spaces to every cell; s_axis_tready stays low until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module block_graphics_pixel_plotter #(
  parameter int unsigned CELLS_PER_ROW = bgp_pkg::DefCellsPerRow,
  parameter int unsigned CELL_ROWS     = bgp_pkg::DefCellRows
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [6:0] pixel_x, [12:7] pixel_y, [20:13] line_end_x, [30:21] cell_index
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] cell_value
  output logic [7:0]       m_axis_tdata,
  // [0] command_done
  output logic             m_axis_tuser
);
  import bgp_pkg::*;

  localparam int unsigned CellCount = CELLS_PER_ROW * CELL_ROWS;
  localparam int unsigned AW        = $clog2(CellCount);

  localparam logic [2:0] StInit  = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRun   = 3'd2;
  localparam logic [2:0] StWb    = 3'd3;
  localparam logic [2:0] StRdout = 3'd4;
  localparam logic [2:0] StClr   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [7:0]       x_q, x_d;
  logic [7:0]       xe_q, xe_d;
  logic [5:0]       y_q, y_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [2:0]       bit_q, bit_d;
  logic             rng_q, rng_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  logic [CellW-1:0] out_data_q, out_data_d;

  cmd_e             cmd;
  logic [6:0]       in_px;
  logic [5:0]       in_py;
  logic [7:0]       in_xe;
  logic [9:0]       in_idx;
  logic             in_rng;
  logic             accept;
  logic             idle;

  logic [7:0]       probe_x;
  logic [5:0]       probe_y;
  logic [7:0]       probe_xe;
  logic             empty;
  logic [AW-1:0]    map_addr;
  pix_loc_t         map_loc;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [CellW-1:0] rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [CellW-1:0] wr_data;
  logic [CellW-1:0] gfx_base;
  logic             clr_last;

  assign cmd    = cmd_e'(s_axis_tuser);
  assign in_px  = s_axis_tdata[6:0];
  assign in_py  = s_axis_tdata[12:7];
  assign in_xe  = s_axis_tdata[20:13];
  assign in_idx = s_axis_tdata[30:21];
  assign in_rng = 32'(in_idx) < CellCount;

  assign idle          = state_q == StIdle;
  assign s_axis_tready = idle && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign probe_x  = idle ? {1'b0, in_px} : x_q;
  assign probe_y  = idle ? in_py : y_q;
  assign probe_xe = !idle ? xe_q : (cmd == CMD_PLOT) ? {1'b0, in_px} + 8'd1 : in_xe;
  assign empty    = probe_x >= probe_xe;
  assign clr_last = clr_q == AW'(CellCount - 1);

  bgp_pixel_map #(
    .CELLS_PER_ROW (CELLS_PER_ROW),
    .CELL_ROWS     (CELL_ROWS),
    .AW            (AW)
  ) u_map (
    .pixel_x_i   (probe_x),
    .pixel_y_i   (probe_y),
    .cell_addr_o (map_addr),
    .loc_o       (map_loc)
  );

  bgp_cell_ram #(
    .DEPTH (CellCount),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    gfx_base = (rd_data inside {[GfxLow:GfxHigh]}) ? rd_data : GfxLow;

    state_d     = state_q;
    x_d         = x_q;
    xe_d        = xe_q;
    y_d         = y_q;
    addr_d      = addr_q;
    bit_d       = bit_q;
    rng_d       = rng_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    rd_en       = 1'b0;
    rd_addr     = map_addr;
    wr_en       = 1'b0;
    wr_addr     = addr_q;
    wr_data     = gfx_base | (CellW'(1) << bit_q);

    case (state_q)
      StInit: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = SpaceCode;
        clr_d   = clr_q + AW'(1);
        if (clr_last) begin
          clr_d   = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          case (cmd)
            CMD_CLEAR: begin
              clr_d   = '0;
              state_d = StClr;
            end
            CMD_PLOT, CMD_LINE: begin
              y_d  = in_py;
              xe_d = probe_xe;
              if (empty) begin
                out_valid_d = 1'b1;
                out_data_d  = '0;
              end else if (map_loc.on_screen) begin
                rd_en   = 1'b1;
                addr_d  = map_addr;
                bit_d   = map_loc.bit_sel;
                x_d     = probe_x;
                state_d = StWb;
              end else begin
                x_d     = probe_x + 8'd1;
                state_d = StRun;
              end
            end
            CMD_READ: begin
              rd_en   = 1'b1;
              rd_addr = in_rng ? AW'(in_idx) : '0;
              rng_d   = in_rng;
              state_d = StRdout;
            end
            default: ;
          endcase
        end
      end
      StRun: begin
        if (empty) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          state_d     = StIdle;
        end else if (map_loc.on_screen) begin
          rd_en   = 1'b1;
          addr_d  = map_addr;
          bit_d   = map_loc.bit_sel;
          state_d = StWb;
        end else begin
          x_d = x_q + 8'd1;
        end
      end
      StWb: begin
        wr_en = 1'b1;
        x_d   = x_q + 8'd1;
        if (x_q + 8'd1 >= xe_q) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          state_d     = StIdle;
        end else begin
          state_d = StRun;
        end
      end
      StRdout: begin
        out_valid_d = 1'b1;
        out_data_d  = rng_q ? rd_data : '0;
        state_d     = StIdle;
      end
      StClr: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = SpaceCode;
        clr_d   = clr_q + AW'(1);
        if (clr_last) begin
          clr_d       = '0;
          out_valid_d = 1'b1;
          out_data_d  = '0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    xe_q       <= xe_d;
    y_q        <= y_d;
    addr_q     <= addr_d;
    bit_q      <= bit_d;
    rng_q      <= rng_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = 1'b1;

endmodule

`default_nettype wire

### rtl/bgp_checker.sv
// ----------------------------------------------------------------------------
// bgp_checker
// Port-level checks for the pixel plotter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bgp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tuser
);
  import bgp_pkg::*;

  logic last_read_q, last_read_d;

  assign last_read_d = (s_axis_tvalid && s_axis_tready) ?
                       (cmd_e'(s_axis_tuser) == CMD_READ) : last_read_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_read_q <= 1'b0;
    end else begin
      last_read_q <= last_read_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_done_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == 1'b1)
    else $error("command_done low on result beat");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !last_read_q |-> m_axis_tdata == 8'd0)
    else $error("nonzero cell_value for a non-read command");

  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while a result is stalled");

endmodule

bind block_graphics_pixel_plotter bgp_checker u_bgp_checker (.*);

`default_nettype wire

### dv/tb_block_graphics_pixel_plotter.sv
// ----------------------------------------------------------------------------
// tb_block_graphics_pixel_plotter
// Drives clear, plot, line and read beats into the plotter and keeps its own
// copy of the 2x3 block-graphics screen. Every result beat is checked against
// the predicted cell byte and done flag, across phases of source and sink
// backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_block_graphics_pixel_plotter;
  import bgp_pkg::*;

  localparam int CellsPerRow = DefCellsPerRow;
  localparam int CellRows    = DefCellRows;
  localparam int CellCount   = CellsPerRow * CellRows;
  localparam int RandItems   = 1520;
  localparam int CycleLimit  = 4000000;
  localparam int DrainCycles = 40;

  typedef struct {
    cmd_e       cmd;
    logic [6:0] px;
    logic [5:0] py;
    logic [7:0] xe;
    logic [9:0] idx;
  } plot_cmd_t;

  typedef struct {
    logic [7:0] value;
    logic       done;
  } cell_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data = '0;
  logic [1:0]  s_user = CMD_CLEAR;
  logic        m_ready = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [7:0]  m_data;
  wire         m_user;

  plot_cmd_t    pending_cmds[$];
  plot_cmd_t    cur_cmd;
  cell_result_t expected_results[$];
  logic [7:0]   screen_model[CellCount];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int checked        = 0;
  int accepted       = 0;
  int total_items    = 0;
  int cycle_count    = 0;
  int cmd_count[4]   = '{0, 0, 0, 0};
  int last_x         = 0;
  int last_y         = 0;

  block_graphics_pixel_plotter #(
    .CELLS_PER_ROW(CellsPerRow),
    .CELL_ROWS    (CellRows)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------- screen model ----------------
  function automatic void clear_screen();
    for (int i = 0; i < CellCount; i++) screen_model[i] = SpaceCode;
  endfunction

  function automatic void plot_pixel(int x, int y);
    int col;
    int row;
    int addr;
    logic [7:0] b;
    col = x / 2;
    row = y / 3;
    if (col >= CellsPerRow || row >= CellRows) return;
    addr = row * CellsPerRow + col;
    b = screen_model[addr];
    if (b < GfxLow || b > GfxHigh) b = GfxLow;
    b[(x % 2) + 2 * (y % 3)] = 1'b1;
    screen_model[addr] = b;
  endfunction

  function automatic void apply_plot_cmd(plot_cmd_t c);
    cell_result_t r;
    r.value = '0;
    r.done  = 1'b1;
    case (c.cmd)
      CMD_CLEAR: clear_screen();
      CMD_PLOT:  plot_pixel(c.px, c.py);
      CMD_LINE: begin
        for (int i = c.px; i < c.xe; i++) plot_pixel(i, c.py);
      end
      default: begin
        if (c.idx < CellCount) r.value = screen_model[c.idx];
      end
    endcase
    cmd_count[c.cmd]++;
    accepted++;
    expected_results.push_back(r);
  endfunction

  // ---------------- stimulus ----------------
  function automatic plot_cmd_t make_cmd(cmd_e cmd, int x, int y, int xe, int idx);
    plot_cmd_t c;
    c.cmd = cmd;
    c.px  = 7'(x);
    c.py  = 6'(y);
    c.xe  = 8'(xe);
    c.idx = 10'(idx);
    return c;
  endfunction

  function automatic int rand_row();
    if ($urandom_range(99) < 85) return $urandom_range(47);
    return $urandom_range(63, 48);
  endfunction

  function automatic plot_cmd_t rand_cmd();
    plot_cmd_t c;
    int sel;
    int span;
    c = make_cmd(CMD_READ, $urandom_range(127), $urandom_range(63),
                 $urandom_range(255), $urandom_range(1023));
    sel = $urandom_range(99);
    if (sel < 2) begin
      c.cmd = CMD_CLEAR;
    end else if (sel < 42) begin
      c.cmd  = CMD_PLOT;
      c.py   = 6'(rand_row());
      last_x = c.px;
      last_y = c.py;
    end else if (sel < 65) begin
      c.cmd  = CMD_LINE;
      c.py   = 6'(rand_row());
      span   = $urandom_range(99);
      if (span < 70) c.xe = 8'(c.px + $urandom_range(24));
      else if (span < 85) c.xe = 8'($urandom_range(255));
      else c.xe = 8'($urandom_range(c.px));
      last_x = c.px;
      last_y = c.py;
    end else begin
      c.cmd = CMD_READ;
      span  = $urandom_range(99);
      if (last_y < 48 && span < 55) begin
        c.idx = 10'((last_y / 3) * CellsPerRow + last_x / 2);
      end else if (last_y < 48 && span < 70) begin
        c.idx = 10'(((last_y / 3) * CellsPerRow + last_x / 2 + $urandom_range(8))
                    % CellCount);
      end
    end
    return c;
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk_i) begin : driver_proc
    plot_cmd_t c;
    if (rst_ni) begin
      if (s_valid && s_ready) apply_plot_cmd(cur_cmd);
      if (!s_valid || s_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          cur_cmd <= c;
          s_valid <= 1'b1;
          s_data  <= {1'b0, c.idx, c.xe, c.py, c.px};
          s_user  <= c.cmd;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  task automatic report_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin : monitor_proc
    cell_result_t want;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat, cell_value", -1, m_data);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (m_data !== want.value) report_mismatch("cell_value", want.value, m_data);
          if (m_user !== want.done) report_mismatch("command_done", want.done, m_user);
        end
      end
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("tb_block_graphics_pixel_plotter: FAIL");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    clear_screen();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, corners, off-screen rows, line edge cases
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 127, 63, 255, 1023));
    pending_cmds.push_back(make_cmd(CMD_PLOT, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_PLOT, 1, 2, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_PLOT, 127, 47, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 1023));
    pending_cmds.push_back(make_cmd(CMD_PLOT, 5, 48, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_PLOT, 127, 63, 255, 1023));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 2));
    pending_cmds.push_back(make_cmd(CMD_LINE, 0, 5, 128, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 64));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 127));
    pending_cmds.push_back(make_cmd(CMD_LINE, 10, 20, 10, 0));
    pending_cmds.push_back(make_cmd(CMD_LINE, 100, 20, 3, 0));
    pending_cmds.push_back(make_cmd(CMD_LINE, 120, 44, 255, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 14 * 64 + 63));
    pending_cmds.push_back(make_cmd(CMD_LINE, 3, 60, 40, 0));
    pending_cmds.push_back(make_cmd(CMD_LINE, 7, 46, 8, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 15 * 64 + 3));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 127, 63, 255, 1023));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 64));
    pending_cmds.push_back(make_cmd(CMD_PLOT, 64, 24, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 8 * 64 + 32));
    total_items = pending_cmds.size();

    for (int ph = 0; ph < 4; ph++) begin
      while (accepted < total_items) @(posedge clk_i);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int i = 0; i < RandItems / 4; i++) pending_cmds.push_back(rand_cmd());
      total_items += RandItems / 4;
    end

    while (checked < total_items) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d clears, %0d plots, %0d lines, %0d reads over four backpressure phases",
             cmd_count[CMD_CLEAR], cmd_count[CMD_PLOT], cmd_count[CMD_LINE],
             cmd_count[CMD_READ]);
    $display("%0d result beats checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_block_graphics_pixel_plotter: PASS");
    end else begin
      $display("tb_block_graphics_pixel_plotter: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bgp_pkg.sv
rtl/bgp_cell_ram.sv
rtl/bgp_pixel_map.sv
rtl/block_graphics_pixel_plotter.sv
rtl/bgp_checker.sv
dv/tb_block_graphics_pixel_plotter.sv
